FILE: design/ehm_pkg.sv
// types, constants and helpers shared by the hour meter files
// no dependencies
package ehm_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PRESS   = 2'd1,
		OP_RESTORE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE   = 3'd0,
		CFG_DOUBLE_MIN = 3'd1,
		CFG_DOUBLE_MAX = 3'd2,
		CFG_PRESSES    = 3'd3,
		CFG_WRAP       = 3'd4,
		CFG_WARN       = 3'd5
	} cfg_idx_t;

	localparam int CNT_W   = 32;
	localparam int MS_W    = 16;
	localparam int PRESS_W = 5;
	localparam int QUOT_W  = 24;

	localparam logic [MS_W-1:0]    DEBOUNCE_RST   = 16'd200;
	localparam logic [MS_W-1:0]    DOUBLE_MIN_RST = 16'd250;
	localparam logic [MS_W-1:0]    DOUBLE_MAX_RST = 16'd500;
	localparam logic [PRESS_W-1:0] PRESSES_RST    = 5'd30;
	localparam logic [CNT_W-1:0]   WRAP_RST       = 32'd360000;
	localparam logic [CNT_W-1:0]   WARN_RST       = 32'd359940;

	// v/300 = (v>>2)/75, reciprocal of 75 scaled by 2^37, exact for 30-bit operands
	localparam logic [30:0] RECIP_75 = 31'd1832519380;
	localparam int          RECIP_SH = 37;

	typedef struct packed {
		logic [MS_W-1:0]    debounce_ms;
		logic [MS_W-1:0]    double_min_ms;
		logic [MS_W-1:0]    double_max_ms;
		logic [PRESS_W-1:0] presses_to_clear;
		logic [CNT_W-1:0]   wrap_seconds;
		logic [CNT_W-1:0]   warn_seconds;
	} cfg_t;

	typedef struct packed {
		op_t              opcode;
		logic [CNT_W-1:0] now_ms;
		logic [CNT_W-1:0] stored_total;
		logic [CNT_W-1:0] stored_trip;
		logic [QUOT_W-1:0] quot_total;
		logic [QUOT_W-1:0] quot_trip;
	} stage_t;

	function automatic logic [QUOT_W-1:0] div300(input logic [CNT_W-1:0] v);
		logic [60:0] prod;
		prod = 61'(v[CNT_W-1:2]) * 61'(RECIP_75);
		return prod[RECIP_SH +: QUOT_W];
	endfunction

endpackage

FILE: design/ehm_if.sv
// handshake channels of the hour meter: event words in, display words out
// depends on ehm_pkg
interface ehm_evt_if;
	logic                     valid;
	logic                     ready;
	ehm_pkg::op_t             opcode;
	logic [ehm_pkg::CNT_W-1:0] now_ms;
	logic [ehm_pkg::CNT_W-1:0] stored_total;
	logic [ehm_pkg::CNT_W-1:0] stored_trip;

	modport source(output valid, opcode, now_ms, stored_total, stored_trip, input ready);
	modport sink(input valid, opcode, now_ms, stored_total, stored_trip, output ready);
endinterface

interface ehm_disp_if;
	logic                     valid;
	logic                     ready;
	logic [ehm_pkg::CNT_W-1:0] shown_value;
	logic                     blank;
	logic                     colon_on;
	logic                     trip_view;
	logic                     clear_total_store;
	logic                     clear_trip_store;

	modport source(output valid, shown_value, blank, colon_on, trip_view,
		clear_total_store, clear_trip_store, input ready);
	modport sink(input valid, shown_value, blank, colon_on, trip_view,
		clear_total_store, clear_trip_store, output ready);
endinterface

FILE: design/ehm_cfg.sv
// configuration registers of the hour meter, plain write port
// depends on ehm_pkg
module ehm_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ehm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ehm_pkg::CNT_W-1:0]       cfg_wdata,
	output ehm_pkg::cfg_t                   cfg
);
	ehm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= ehm_pkg::DEBOUNCE_RST;
			cfg_q.double_min_ms    <= ehm_pkg::DOUBLE_MIN_RST;
			cfg_q.double_max_ms    <= ehm_pkg::DOUBLE_MAX_RST;
			cfg_q.presses_to_clear <= ehm_pkg::PRESSES_RST;
			cfg_q.wrap_seconds     <= ehm_pkg::WRAP_RST;
			cfg_q.warn_seconds     <= ehm_pkg::WARN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ehm_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms <= cfg_wdata[ehm_pkg::MS_W-1:0];
				ehm_pkg::CFG_DOUBLE_MIN: cfg_q.double_min_ms <= cfg_wdata[ehm_pkg::MS_W-1:0];
				ehm_pkg::CFG_DOUBLE_MAX: cfg_q.double_max_ms <= cfg_wdata[ehm_pkg::MS_W-1:0];
				ehm_pkg::CFG_PRESSES:
					cfg_q.presses_to_clear <= cfg_wdata[ehm_pkg::PRESS_W-1:0];
				ehm_pkg::CFG_WRAP:       cfg_q.wrap_seconds <= cfg_wdata;
				ehm_pkg::CFG_WARN:       cfg_q.warn_seconds <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

FILE: design/ehm_prep.sv
// input stage: registers the event word and the restore quotients (v/300)
// depends on ehm_pkg and ehm_evt_if
module ehm_prep (
	input  logic             clk,
	input  logic             arst_n,
	ehm_evt_if.sink          evt,
	input  logic             take,
	output logic             valid_s1,
	output ehm_pkg::stage_t  stage_s1
);
	logic            vld_s1;
	ehm_pkg::stage_t data_s1;
	logic            accept;

	assign evt.ready = !vld_s1 || take;
	assign accept    = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			vld_s1 <= evt.valid;
		end
	end

	// cleared at reset so the opcode decode never sees an unknown word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s1 <= '0;
		end else if (accept) begin
			data_s1.opcode       <= evt.opcode;
			data_s1.now_ms       <= evt.now_ms;
			data_s1.stored_total <= evt.stored_total;
			data_s1.stored_trip  <= evt.stored_trip;
			data_s1.quot_total   <= ehm_pkg::div300(evt.stored_total);
			data_s1.quot_trip    <= ehm_pkg::div300(evt.stored_trip);
		end
	end

	assign valid_s1 = vld_s1;
	assign stage_s1 = data_s1;
endmodule

FILE: design/ehm_core.sv
// meter state, event processing and the display result register
// depends on ehm_pkg and ehm_disp_if
module ehm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ehm_pkg::cfg_t    cfg,
	input  logic             valid_s1,
	input  ehm_pkg::stage_t  stage_s1,
	output logic             take,
	ehm_disp_if.source       disp
);
	localparam int CNT_W   = ehm_pkg::CNT_W;
	localparam int PRESS_W = ehm_pkg::PRESS_W;

	logic [CNT_W-1:0]   total_q, trip_q, push_q, accept_q;
	logic               show_trip_q, skip_q;
	logic [PRESS_W-1:0] press_q;

	logic [CNT_W-1:0]   total_n, trip_n, push_n, accept_n;
	logic               show_trip_n, skip_n;
	logic [PRESS_W-1:0] press_n;
	logic               clr_total, clr_trip;
	logic [CNT_W-1:0]   gap, since_accept;
	logic               dbl;

	logic [CNT_W-1:0]   value;
	logic               blank, colon;

	logic               out_vld_q;
	logic [CNT_W-1:0]   value_q;
	logic               blank_q, colon_q, view_q, clr_total_q, clr_trip_q;

	assign take = valid_s1 && (!out_vld_q || disp.ready);

	always_comb begin
		total_n     = total_q;
		trip_n      = trip_q;
		push_n      = push_q;
		accept_n    = accept_q;
		show_trip_n = show_trip_q;
		skip_n      = skip_q;
		press_n     = press_q;
		clr_total   = 1'b0;
		clr_trip    = 1'b0;
		since_accept = stage_s1.now_ms - accept_q;
		gap          = stage_s1.now_ms - push_q;
		dbl          = gap >= CNT_W'(cfg.double_min_ms) && gap <= CNT_W'(cfg.double_max_ms);
		unique case (stage_s1.opcode)
			ehm_pkg::OP_TICK: begin
				if (skip_q) begin
					skip_n = 1'b0;
				end else begin
					total_n = total_q + CNT_W'(1);
				end
				trip_n = trip_q + CNT_W'(1);
				// the wrap test runs on every tick, skipped or not
				if (total_n == cfg.wrap_seconds) begin
					total_n   = '0;
					skip_n    = 1'b1;
					clr_total = 1'b1;
				end
			end
			ehm_pkg::OP_PRESS: begin
				if (since_accept >= CNT_W'(cfg.debounce_ms)) begin
					if (dbl) begin
						show_trip_n = !show_trip_q;
						press_n     = '0;
					end else begin
						push_n = stage_s1.now_ms;
					end
					press_n  = press_n + PRESS_W'(1);
					accept_n = stage_s1.now_ms;
					if (press_n == cfg.presses_to_clear) begin
						if (show_trip_n) begin
							trip_n   = '0;
							clr_trip = 1'b1;
						end
						press_n = '0;
					end
				end
			end
			ehm_pkg::OP_RESTORE: begin
				total_n = stage_s1.stored_total + CNT_W'(stage_s1.quot_total) + CNT_W'(1);
				trip_n  = stage_s1.stored_trip + CNT_W'(stage_s1.quot_trip) + CNT_W'(1);
			end
			ehm_pkg::OP_NONE: ;
		endcase
	end

	// display rule works on the updated state
	always_comb begin
		if (!show_trip_n) begin
			value = total_n;
			if (total_n >= cfg.warn_seconds) begin
				blank = total_n[0];
				colon = 1'b1;
			end else begin
				blank = total_n == '0;
				colon = total_n[0];
			end
		end else begin
			value = trip_n;
			blank = trip_n == '0;
			colon = trip_n[0];
		end
		if (blank) begin
			value = '0;
			colon = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			trip_q      <= '0;
			push_q      <= '0;
			accept_q    <= '0;
			show_trip_q <= 1'b0;
			skip_q      <= 1'b0;
			press_q     <= '0;
		end else if (take) begin
			total_q     <= total_n;
			trip_q      <= trip_n;
			push_q      <= push_n;
			accept_q    <= accept_n;
			show_trip_q <= show_trip_n;
			skip_q      <= skip_n;
			press_q     <= press_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || disp.ready) begin
			out_vld_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q     <= value;
			blank_q     <= blank;
			colon_q     <= colon;
			view_q      <= show_trip_n;
			clr_total_q <= clr_total;
			clr_trip_q  <= clr_trip;
		end
	end

	assign disp.valid             = out_vld_q;
	assign disp.shown_value       = value_q;
	assign disp.blank             = blank_q;
	assign disp.colon_on          = colon_q;
	assign disp.trip_view         = view_q;
	assign disp.clear_total_store = clr_total_q;
	assign disp.clear_trip_store  = clr_trip_q;
endmodule

FILE: design/engine_hour_meter_controller.sv
// Engine hour meter with total and trip seconds counters. Each event word (tick, button
// press, restore, no-op) gives one display word, through the input register, where
// restore values are divided by 300 by a reciprocal multiply, and the result register
// after the state update. A new event is taken every cycle while the display side takes
// words; state update and display logic sit between the two registers. The user writes
// configuration through cfg_we/cfg_index/cfg_wdata only while idle, not enforced here.
module engine_hour_meter_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ehm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ehm_pkg::CNT_W-1:0]     cfg_wdata,
	ehm_evt_if.sink                       evt,
	ehm_disp_if.source                    disp
);
	ehm_pkg::cfg_t   cfg;
	ehm_pkg::stage_t stage_s1;
	logic            valid_s1;
	logic            take;

	ehm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ehm_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.take     (take),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	ehm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.take     (take),
		.disp     (disp)
	);
endmodule

FILE: tb/sv/ehm_meter_watch.sv
// watches the event and display channels of the hour meter, predicts each display word
// and compares it with the word that comes out; depends on ehm_pkg and ehm_if
module ehm_meter_watch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ehm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ehm_pkg::CNT_W-1:0]     cfg_wdata,
	ehm_evt_if                            evt,
	ehm_disp_if                           disp,
	output int                            mismatches,
	output int                            pending,
	output int                            words_checked,
	output int                            total_clears,
	output int                            trip_clears
);
	import ehm_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0] shown_value;
		logic             blank;
		logic             colon_on;
		logic             trip_view;
		logic             clear_total_store;
		logic             clear_trip_store;
	} disp_word_t;

	// register copies
	logic [MS_W-1:0]    debounce_lim;
	logic [MS_W-1:0]    double_lo;
	logic [MS_W-1:0]    double_hi;
	logic [PRESS_W-1:0] presses_lim;
	logic [CNT_W-1:0]   wrap_lim;
	logic [CNT_W-1:0]   warn_lim;

	// meter state
	logic [CNT_W-1:0]   total_secs;
	logic [CNT_W-1:0]   trip_secs;
	logic               trip_shown;
	logic               skip_tick;
	logic [CNT_W-1:0]   last_push_ms;
	logic [CNT_W-1:0]   last_accept_ms;
	logic [PRESS_W-1:0] press_cnt;

	disp_word_t disp_due[$];

	function automatic disp_word_t advance_meter(input op_t op, input logic [CNT_W-1:0] now,
		input logic [CNT_W-1:0] st_tot, input logic [CNT_W-1:0] st_trp);
		disp_word_t       w;
		logic [CNT_W-1:0] gap;
		logic [CNT_W-1:0] val;
		logic             blk;
		logic             col;
		w = '0;
		case (op)
			OP_TICK: begin
				if (skip_tick)
					skip_tick = 1'b0;
				else
					total_secs = total_secs + 1'b1;
				trip_secs = trip_secs + 1'b1;
				// equality only, so a total above the limit runs on past it
				if (total_secs == wrap_lim) begin
					total_secs = '0;
					skip_tick = 1'b1;
					w.clear_total_store = 1'b1;
				end
			end
			OP_PRESS: begin
				if (CNT_W'(now - last_accept_ms) >= CNT_W'(debounce_lim)) begin
					gap = now - last_push_ms;
					if (gap >= CNT_W'(double_lo) && gap <= CNT_W'(double_hi)) begin
						trip_shown = !trip_shown;
						press_cnt = '0;
					end else begin
						last_push_ms = now;
					end
					press_cnt = press_cnt + 1'b1;
					last_accept_ms = now;
					if (press_cnt == presses_lim) begin
						if (trip_shown) begin
							trip_secs = '0;
							w.clear_trip_store = 1'b1;
						end
						press_cnt = '0;
					end
				end
			end
			OP_RESTORE: begin
				total_secs = st_tot + st_tot / 32'd300 + 1'b1;
				trip_secs = st_trp + st_trp / 32'd300 + 1'b1;
			end
			default: ;
		endcase

		if (!trip_shown) begin
			val = total_secs;
			// warning blink in the last stretch before the wrap
			if (total_secs >= warn_lim) begin
				blk = total_secs[0];
				col = 1'b1;
			end else begin
				blk = total_secs == '0;
				col = total_secs[0];
			end
		end else begin
			val = trip_secs;
			blk = trip_secs == '0;
			col = trip_secs[0];
		end
		if (blk) begin
			val = '0;
			col = 1'b0;
		end
		w.shown_value = val;
		w.blank = blk;
		w.colon_on = col;
		w.trip_view = trip_shown;
		return w;
	endfunction

	function automatic void check_field(input string field, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		disp_word_t want;
		if (!arst_n) begin
			debounce_lim = DEBOUNCE_RST;
			double_lo = DOUBLE_MIN_RST;
			double_hi = DOUBLE_MAX_RST;
			presses_lim = PRESSES_RST;
			wrap_lim = WRAP_RST;
			warn_lim = WARN_RST;
			total_secs = '0;
			trip_secs = '0;
			trip_shown = 1'b0;
			skip_tick = 1'b0;
			last_push_ms = '0;
			last_accept_ms = '0;
			press_cnt = '0;
			disp_due.delete();
			mismatches = 0;
			pending = 0;
			words_checked = 0;
			total_clears = 0;
			trip_clears = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEBOUNCE:   debounce_lim = cfg_wdata[MS_W-1:0];
					CFG_DOUBLE_MIN: double_lo = cfg_wdata[MS_W-1:0];
					CFG_DOUBLE_MAX: double_hi = cfg_wdata[MS_W-1:0];
					CFG_PRESSES:    presses_lim = cfg_wdata[PRESS_W-1:0];
					CFG_WRAP:       wrap_lim = cfg_wdata;
					CFG_WARN:       warn_lim = cfg_wdata;
					default: ;
				endcase
			end
			// older word leaves before a new event is predicted
			if (disp.valid && disp.ready) begin
				words_checked++;
				if (disp_due.size() == 0) begin
					$error("display word with none expected: value %0h", disp.shown_value);
					mismatches++;
				end else begin
					want = disp_due.pop_front();
					check_field("shown_value", want.shown_value, disp.shown_value);
					check_field("blank", want.blank, disp.blank);
					check_field("colon_on", want.colon_on, disp.colon_on);
					check_field("trip_view", want.trip_view, disp.trip_view);
					check_field("clear_total_store", want.clear_total_store,
						disp.clear_total_store);
					check_field("clear_trip_store", want.clear_trip_store,
						disp.clear_trip_store);
				end
			end
			if (evt.valid && evt.ready) begin
				want = advance_meter(evt.opcode, evt.now_ms, evt.stored_total, evt.stored_trip);
				if (want.clear_total_store)
					total_clears++;
				if (want.clear_trip_store)
					trip_clears++;
				disp_due.push_back(want);
			end
			pending = disp_due.size();
		end
	end

endmodule

FILE: tb/sv/engine_hour_meter_controller_tb.sv
// top of the hour meter bench: clock, reset, register settings and event words
// depends on ehm_pkg, ehm_if, the meter rtl and ehm_meter_watch
module engine_hour_meter_controller_tb;
	import ehm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 230;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CNT_W-1:0] cfg_wdata;

	int mismatches;
	int pending;
	int words_checked;
	int total_clears;
	int trip_clears;

	logic [CNT_W-1:0] cfg_shadow [6];
	logic [CNT_W-1:0] press_ms;
	int               ops_sent [4];
	int               settings;
	int               cycles;
	int               run_left;
	bit               src_burst;
	bit               snk_burst;

	ehm_evt_if  evt_ch();
	ehm_disp_if disp_ch();

	engine_hour_meter_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.disp      (disp_ch)
	);

	ehm_meter_watch i_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.evt           (evt_ch),
		.disp          (disp_ch),
		.mismatches    (mismatches),
		.pending       (pending),
		.words_checked (words_checked),
		.total_clears  (total_clears),
		.trip_clears   (trip_clears)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[engine_hour_meter_controller] ERROR");
			$finish;
		end
	end

	task automatic send_event(input op_t op, input logic [CNT_W-1:0] now,
		input logic [CNT_W-1:0] st_tot, input logic [CNT_W-1:0] st_trp);
		int unsigned idle;
		if (($urandom_range(0, 63)) == 0)
			src_burst = ($urandom_range(0, 2) == 0);
		idle = src_burst ? 0 : $urandom_range(0, 6);
		if (idle != 0) begin
			evt_ch.valid = 1'b0;
			repeat (idle) @(negedge clk);
		end
		evt_ch.valid = 1'b1;
		evt_ch.opcode = op;
		evt_ch.now_ms = now;
		evt_ch.stored_total = st_tot;
		evt_ch.stored_trip = st_trp;
		do @(posedge clk); while (!evt_ch.ready);
		@(negedge clk);
		ops_sent[op]++;
	endtask

	task automatic wait_idle();
		evt_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		cfg_shadow[idx] = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_registers(input logic [CNT_W-1:0] dbn, input logic [CNT_W-1:0] dmin,
		input logic [CNT_W-1:0] dmax, input logic [CNT_W-1:0] prs,
		input logic [CNT_W-1:0] wrp, input logic [CNT_W-1:0] wrn);
		wait_idle();
		write_reg(CFG_DEBOUNCE, dbn);
		write_reg(CFG_DOUBLE_MIN, dmin);
		write_reg(CFG_DOUBLE_MAX, dmax);
		write_reg(CFG_PRESSES, prs);
		write_reg(CFG_WRAP, wrp);
		write_reg(CFG_WARN, wrn);
		settings++;
	endtask

	// press time: bounce, double-press window, plain press, or anywhere at all
	function automatic logic [CNT_W-1:0] next_press_ms(input bit plain);
		int unsigned pick;
		logic [CNT_W-1:0] dbn;
		logic [CNT_W-1:0] dmin;
		logic [CNT_W-1:0] dmax;
		pick = plain ? 60 : $urandom_range(0, 99);
		dbn = cfg_shadow[CFG_DEBOUNCE];
		dmin = cfg_shadow[CFG_DOUBLE_MIN];
		dmax = cfg_shadow[CFG_DOUBLE_MAX];
		if (pick < 25)
			press_ms = press_ms + ((dbn == 0) ? 0 : $urandom_range(0, dbn - 1));
		else if (pick < 55)
			press_ms = press_ms + $urandom_range(dmin, (dmax < dmin) ? dmin : dmax);
		else if (pick < 90)
			press_ms = press_ms + ((dmax > dbn) ? dmax : dbn) + $urandom_range(1, 3000);
		else
			press_ms = $urandom();
		return press_ms;
	endfunction

	// saved count that restores to just below the wrap, a small one, or any value
	function automatic logic [CNT_W-1:0] restore_seed();
		longint unsigned base;
		int unsigned     sub;
		int unsigned     pick;
		pick = $urandom_range(0, 3);
		if (pick < 2) begin
			base = 64'(cfg_shadow[CFG_WRAP]) * 300 / 301;
			sub = $urandom_range(0, 8);
			return (base > sub) ? CNT_W'(base - sub) : '0;
		end else if (pick == 2) begin
			return $urandom_range(0, 1000);
		end
		return $urandom();
	endfunction

	task automatic send_random();
		int unsigned pick;
		if (run_left > 0) begin
			// run of plain presses to reach the press count that clears the trip
			run_left--;
			send_event(OP_PRESS, next_press_ms(1'b1), $urandom(), $urandom());
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				run_left = cfg_shadow[CFG_PRESSES] + 2;
				send_event(OP_PRESS, next_press_ms(1'b0), $urandom(), $urandom());
			end else if (pick < 42)
				send_event(OP_TICK, $urandom(), $urandom(), $urandom());
			else if (pick < 85)
				send_event(OP_PRESS, next_press_ms(1'b0), $urandom(), $urandom());
			else if (pick < 97)
				send_event(OP_RESTORE, $urandom(), restore_seed(), restore_seed());
			else
				send_event(OP_NONE, $urandom(), $urandom(), $urandom());
		end
	endtask

	task automatic random_phase();
		repeat (RANDOM_PER_PHASE)
			send_random();
	endtask

	initial begin
		disp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned idle;
			if ($urandom_range(0, 49) == 0)
				snk_burst = ($urandom_range(0, 2) == 0);
			idle = snk_burst ? 0 : $urandom_range(0, 6);
			if (idle != 0) begin
				disp_ch.ready = 1'b0;
				repeat (idle) @(negedge clk);
			end
			disp_ch.ready = 1'b1;
			do @(posedge clk); while (!disp_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [CNT_W-1:0] wrp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEBOUNCE;
		cfg_wdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.opcode = OP_NONE;
		evt_ch.now_ms = '0;
		evt_ch.stored_total = '0;
		evt_ch.stored_trip = '0;
		cycles = 0;
		settings = 1;
		run_left = 0;
		press_ms = '0;
		src_burst = 1'b0;
		snk_burst = 1'b0;
		ops_sent = '{default: 0};
		cfg_shadow[CFG_DEBOUNCE] = DEBOUNCE_RST;
		cfg_shadow[CFG_DOUBLE_MIN] = DOUBLE_MIN_RST;
		cfg_shadow[CFG_DOUBLE_MAX] = DOUBLE_MAX_RST;
		cfg_shadow[CFG_PRESSES] = PRESSES_RST;
		cfg_shadow[CFG_WRAP] = WRAP_RST;
		cfg_shadow[CFG_WARN] = WARN_RST;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: debounce edges, double press, warning blink and the wrap
		send_event(OP_PRESS, 32'd0, '0, '0);
		send_event(OP_PRESS, 32'd199, '1, '1);
		send_event(OP_PRESS, 32'd200, '0, '0);
		send_event(OP_PRESS, 32'd450, '0, '0);
		send_event(OP_TICK, '1, '1, '1);
		send_event(OP_PRESS, 32'd951, '0, '0);
		send_event(OP_PRESS, 32'd1451, '0, '0);
		send_event(OP_RESTORE, '0, 32'd358800, 32'd0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_NONE, '1, '1, '1);
		send_event(OP_RESTORE, '0, '1, '1);
		send_event(OP_TICK, '0, '0, '0);
		// timestamp gap across the 2^32 rollover
		send_event(OP_PRESS, 32'hFFFF_FF00, '0, '0);
		send_event(OP_PRESS, 32'h0000_0010, '0, '0);
		send_event(OP_TICK, '0, '0, '0);
		send_event(OP_RESTORE, '0, '0, '0);
		press_ms = 32'h0000_0010;
		random_phase();

		set_registers(0, 0, 0, 1, 1, 0);
		random_phase();
		set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 31, '1, '1);
		random_phase();
		set_registers(0, 0, 16'hFFFF, 1, 12, 8);
		random_phase();
		repeat (4) begin
			wrp = $urandom_range(1, 40);
			set_registers($urandom_range(0, 300), $urandom_range(0, 600), $urandom_range(0, 900),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 8),
				wrp, $urandom_range(0, wrp + 3));
			random_phase();
		end

		wait_idle();
		repeat (4) @(negedge clk);
		$display("covered %0d events (%0d ticks, %0d presses, %0d restores, %0d no-ops) over %0d register settings",
			ops_sent[OP_TICK] + ops_sent[OP_PRESS] + ops_sent[OP_RESTORE] + ops_sent[OP_NONE],
			ops_sent[OP_TICK], ops_sent[OP_PRESS], ops_sent[OP_RESTORE], ops_sent[OP_NONE],
			settings);
		$display("%0d display words compared, %0d total clears and %0d trip clears among them",
			words_checked, total_clears, trip_clears);
		if (mismatches == 0)
			$display("[engine_hour_meter_controller] OK");
		else
			$display("[engine_hour_meter_controller] ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/ehm_pkg.sv
design/ehm_if.sv
design/ehm_cfg.sv
design/ehm_prep.sv
design/ehm_core.sv
design/engine_hour_meter_controller.sv
tb/sv/ehm_meter_watch.sv
tb/sv/engine_hour_meter_controller_tb.sv
